// ===== rtl/core/laplacian_edge_filter_top_macros.svh =====
// assertion macros shared by the edge filter modules
`ifndef LAPLACIAN_EDGE_FILTER_TOP_MACROS_SVH
`define LAPLACIAN_EDGE_FILTER_TOP_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define LEF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LEF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lef_pkg.sv =====
// package: widths, constants and transaction types of the edge filter
`timescale 1ns / 1ps
package lef_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WCNT_W = COL_W + 1;
  localparam int HCNT_W = ROW_W + 1;

  localparam int FW_W      = 12;
  localparam int FH_W      = 13;
  localparam int GAIN_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam int PIX_W     = 8;
  localparam int SUM_W     = 10;
  localparam int MAG_W     = 10;
  localparam int LINE_W    = 2 * PIX_W;
  localparam int RECIP3    = 683;
  localparam int RECIP3_W  = 10;
  localparam int RECIP3_SH = 11;
  localparam int GAIN_FRAC = 8;
  localparam int PIX_MAX   = 255;
  localparam int MIN_DIM   = 3;

  localparam int FW_RESET   = 640;
  localparam int FH_RESET   = 480;
  localparam int GAIN_RESET = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_EDGE_GAIN    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_start;
  } in_payload_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic [COL_W-1:0] pixel_col;
    logic [ROW_W-1:0] pixel_row;
  } out_payload_t;

  // pixel entering the line-buffer stage
  typedef struct packed {
    logic [PIX_W-1:0] bright;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } s1_item_t;

  // absolute laplacian on its way to the gain stage
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } mag_item_t;

  // line buffer write port
  typedef struct packed {
    logic              en;
    logic [COL_W-1:0]  addr;
    logic [LINE_W-1:0] data;
  } ram_wr_t;

endpackage

// ===== rtl/core/lef_line_ram.sv =====
// line buffer memory: above and middle rows packed in one word per column
`timescale 1ns / 1ps
module lef_line_ram (
  input  logic                         clk,
  input  lef_pkg::ram_wr_t             wr,
  input  logic                         rd_en,
  input  logic [lef_pkg::COL_W-1:0]    rd_addr,
  output logic [lef_pkg::LINE_W-1:0]   rd_data
);

  logic [lef_pkg::LINE_W-1:0] mem [lef_pkg::MAX_WIDTH];
  logic [lef_pkg::LINE_W-1:0] rd_data_r;

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/lef_window.sv =====
// window stage: line buffer read-modify-write, forwarding and laplacian
`timescale 1ns / 1ps
`include "laplacian_edge_filter_top_macros.svh"
module lef_window (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_fire,
  input  lef_pkg::s1_item_t           in_item,
  input  logic [lef_pkg::LINE_W-1:0]  rd_data,
  output lef_pkg::ram_wr_t            wr,
  output logic                        s1_ready,
  input  logic                        s2_ready,
  output logic                        mag_valid,
  output lef_pkg::mag_item_t          mag_item
);

  logic                        s1_v_r, s1_v_nxt;
  lef_pkg::s1_item_t           s1_item_r;
  logic                        fwd_v_r, fwd_v_nxt;
  logic [lef_pkg::LINE_W-1:0]  fwd_data_r;
  logic [lef_pkg::PIX_W-1:0]   win0_r, win1_r, win2_r, win3_r;

  logic [lef_pkg::LINE_W-1:0]  line_word;
  logic [lef_pkg::PIX_W-1:0]   above_now, mid_now;
  logic                        advance, produced;
  logic [lef_pkg::MAG_W-1:0]   pos_sum, neg_sum;

  assign line_word = fwd_v_r ? fwd_data_r : rd_data;
  assign above_now = line_word[lef_pkg::LINE_W-1:lef_pkg::PIX_W];
  assign mid_now   = line_word[lef_pkg::PIX_W-1:0];

  assign s1_ready = !s1_v_r || s2_ready;
  assign advance  = s1_v_r && s2_ready;
  assign produced = (s1_item_r.col >= lef_pkg::COL_W'(2)) &&
                    (s1_item_r.row >= lef_pkg::ROW_W'(2));

  assign wr.en   = advance;
  assign wr.addr = s1_item_r.col;
  assign wr.data = {mid_now, s1_item_r.bright};

  // 4*centre against the four neighbours; right neighbour is mid_now
  assign pos_sum = {win0_r, 2'b00};
  assign neg_sum = lef_pkg::MAG_W'(win1_r) + lef_pkg::MAG_W'(win2_r) +
                   lef_pkg::MAG_W'(win3_r) + lef_pkg::MAG_W'(mid_now);

  always_comb begin
    mag_valid    = advance && produced;
    mag_item.mag = (pos_sum >= neg_sum) ? (pos_sum - neg_sum) : (neg_sum - pos_sum);
    mag_item.col = s1_item_r.col - lef_pkg::COL_W'(1);
    mag_item.row = s1_item_r.row - lef_pkg::ROW_W'(1);
  end

  always_comb begin
    s1_v_nxt  = s1_v_r;
    fwd_v_nxt = fwd_v_r;
    if (in_fire) begin
      s1_v_nxt  = 1'b1;
      // previous pixel writes the column being read this cycle
      fwd_v_nxt = advance && (in_item.col == s1_item_r.col);
    end else if (advance) begin
      s1_v_nxt  = 1'b0;
      fwd_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
      win0_r  <= '0;
      win1_r  <= '0;
      win2_r  <= '0;
      win3_r  <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      fwd_v_r <= fwd_v_nxt;
      if (advance) begin
        win1_r <= win0_r;
        win0_r <= mid_now;
        win2_r <= above_now;
        win3_r <= s1_item_r.bright;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r  <= in_item;
      fwd_data_r <= wr.data;
    end
  end

  `LEF_ASSERT_NOW(a_fwd_only_when_loaded, fwd_v_r, s1_v_r, "forward flag without pixel")
  `LEF_ASSERT_NEXT(a_stalled_pixel_stays, s1_v_r && !s2_ready, s1_v_r, "stalled pixel lost")

endmodule

// ===== rtl/core/lef_scale.sv =====
// gain stage: multiply by 8.8 gain, saturate, output register
`timescale 1ns / 1ps
`include "laplacian_edge_filter_top_macros.svh"
module lef_scale (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        mag_valid,
  input  lef_pkg::mag_item_t          mag_item,
  input  logic [lef_pkg::GAIN_W-1:0]  gain,
  output logic                        s2_ready,
  output logic                        out_valid,
  output lef_pkg::out_payload_t       out_data,
  input  logic                        out_stall
);

  localparam int PROD_W = lef_pkg::MAG_W + lef_pkg::GAIN_W;
  localparam int SH_W   = PROD_W - lef_pkg::GAIN_FRAC;

  logic                   s2_v_r, s2_v_nxt;
  lef_pkg::mag_item_t     s2_item_r;
  logic                   out_v_r, out_v_nxt;
  lef_pkg::out_payload_t  out_data_r;
  logic                   out_ready;
  logic [PROD_W-1:0]      product;
  logic [SH_W-1:0]        shifted;
  logic [lef_pkg::PIX_W-1:0] edge_sat;

  assign out_ready = !out_v_r || !out_stall;
  assign s2_ready  = !s2_v_r || out_ready;

  assign product  = PROD_W'(s2_item_r.mag) * PROD_W'(gain);
  assign shifted  = product[PROD_W-1:lef_pkg::GAIN_FRAC];
  assign edge_sat = (shifted > SH_W'(lef_pkg::PIX_MAX)) ? lef_pkg::PIX_W'(lef_pkg::PIX_MAX)
                                                         : shifted[lef_pkg::PIX_W-1:0];

  always_comb begin
    s2_v_nxt  = s2_ready ? mag_valid : s2_v_r;
    out_v_nxt = out_ready ? s2_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && mag_valid) begin
      s2_item_r <= mag_item;
    end
    if (out_ready && s2_v_r) begin
      out_data_r.edge_value <= edge_sat;
      out_data_r.pixel_col  <= s2_item_r.col;
      out_data_r.pixel_row  <= s2_item_r.row;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  `LEF_ASSERT_NOW(a_out_col_interior, out_v_r, out_data_r.pixel_col != '0, "border column out")
  `LEF_ASSERT_NOW(a_out_row_interior, out_v_r, out_data_r.pixel_row != '0, "border row out")

endmodule

// ===== rtl/core/laplacian_edge_filter_top.sv =====
// top level of the 4-neighbour laplacian edge filter
// The filter takes one RGB pixel per clock in raster order and sustains that
// rate while out_stall does not back up the pipeline: the line buffer is a
// single memory with one read and one write per cycle, and a pixel leaving the
// window stage writes back the same column that a following pixel may read,
// covered by a one-entry forward. An accepted pixel's result, if it has one, is
// built in order: the memory read and the laplacian share the window stage,
// then gain multiply and saturation fill the gain stage and the output register.
// A result for
// centre pixel (c, r) comes out when pixel (c+1, r+1) has been taken; the
// first and last row and column give no result. There is no clearing pass
// after reset: line buffer contents only feed a result once the rows above were
// written. Frame size and gain must be written while no pixel is in flight.
`timescale 1ns / 1ps
`include "laplacian_edge_filter_top_macros.svh"
module laplacian_edge_filter_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // pixel input transaction
  input  logic                           in_valid,
  output logic                           in_stall,
  input  lef_pkg::in_payload_t           in_data,
  // result transaction
  output logic                           out_valid,
  input  logic                           out_stall,
  output lef_pkg::out_payload_t          out_data,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [lef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lef_pkg::CFG_W-1:0]      cfg_wdata
);

  // configuration registers
  logic [lef_pkg::FW_W-1:0]   frame_width_r;
  logic [lef_pkg::FH_W-1:0]   frame_height_r;
  logic [lef_pkg::GAIN_W-1:0] edge_gain_r;

  // raster position of the next pixel
  logic [lef_pkg::COL_W-1:0]  col_count_r, col_count_nxt;
  logic [lef_pkg::ROW_W-1:0]  row_count_r, row_count_nxt;

  logic [lef_pkg::WCNT_W-1:0] w_eff, col_inc;
  logic [lef_pkg::HCNT_W-1:0] h_eff, row_inc;
  logic [lef_pkg::COL_W-1:0]  col_cur;
  logic [lef_pkg::ROW_W-1:0]  row_cur;
  logic                       in_fire, s1_ready, s2_ready;

  // brightness through the reciprocal of three
  logic [lef_pkg::SUM_W-1:0]                    rgb_sum;
  logic [lef_pkg::SUM_W+lef_pkg::RECIP3_W-1:0]  rgb_prod;

  lef_pkg::s1_item_t          s1_in;
  lef_pkg::ram_wr_t           ram_wr;
  logic [lef_pkg::LINE_W-1:0] ram_rd_data;
  logic                       mag_valid;
  lef_pkg::mag_item_t         mag_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= lef_pkg::FW_W'(lef_pkg::FW_RESET);
      frame_height_r <= lef_pkg::FH_W'(lef_pkg::FH_RESET);
      edge_gain_r    <= lef_pkg::GAIN_W'(lef_pkg::GAIN_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        lef_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[lef_pkg::FW_W-1:0];
        lef_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[lef_pkg::FH_W-1:0];
        lef_pkg::CFG_EDGE_GAIN:    edge_gain_r    <= cfg_wdata[lef_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // frame size clamped to the legal range
  always_comb begin
    if (frame_width_r < lef_pkg::FW_W'(lef_pkg::MIN_DIM)) begin
      w_eff = lef_pkg::WCNT_W'(lef_pkg::MIN_DIM);
    end else if (32'(frame_width_r) > lef_pkg::MAX_WIDTH) begin
      w_eff = lef_pkg::WCNT_W'(lef_pkg::MAX_WIDTH);
    end else begin
      w_eff = lef_pkg::WCNT_W'(frame_width_r);
    end
    if (frame_height_r < lef_pkg::FH_W'(lef_pkg::MIN_DIM)) begin
      h_eff = lef_pkg::HCNT_W'(lef_pkg::MIN_DIM);
    end else if (32'(frame_height_r) > lef_pkg::MAX_HEIGHT) begin
      h_eff = lef_pkg::HCNT_W'(lef_pkg::MAX_HEIGHT);
    end else begin
      h_eff = lef_pkg::HCNT_W'(frame_height_r);
    end
  end

  assign in_stall = !s1_ready;
  assign in_fire  = in_valid && !in_stall;

  // frame start puts this pixel at (0,0)
  assign col_cur = in_data.frame_start ? '0 : col_count_r;
  assign row_cur = in_data.frame_start ? '0 : row_count_r;
  assign col_inc = lef_pkg::WCNT_W'(col_cur) + lef_pkg::WCNT_W'(1);
  assign row_inc = lef_pkg::HCNT_W'(row_cur) + lef_pkg::HCNT_W'(1);

  always_comb begin
    col_count_nxt = col_count_r;
    row_count_nxt = row_count_r;
    if (in_fire) begin
      if (col_inc >= w_eff) begin
        col_count_nxt = '0;
        row_count_nxt = (row_inc >= h_eff) ? '0 : row_inc[lef_pkg::ROW_W-1:0];
      end else begin
        col_count_nxt = col_inc[lef_pkg::COL_W-1:0];
        row_count_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
    end
  end

  // (r+g+b)/3 exact for every sum up to 765
  assign rgb_sum  = lef_pkg::SUM_W'(in_data.red) + lef_pkg::SUM_W'(in_data.green) +
                    lef_pkg::SUM_W'(in_data.blue);
  assign rgb_prod = (lef_pkg::SUM_W+lef_pkg::RECIP3_W)'(rgb_sum) *
                    (lef_pkg::SUM_W+lef_pkg::RECIP3_W)'(lef_pkg::RECIP3);

  always_comb begin
    s1_in.bright = rgb_prod[lef_pkg::RECIP3_SH +: lef_pkg::PIX_W];
    s1_in.col    = col_cur;
    s1_in.row    = row_cur;
  end

  // line buffer is read as the pixel is taken
  lef_line_ram u_line_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_en   (in_fire),
    .rd_addr (col_cur),
    .rd_data (ram_rd_data)
  );

  lef_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_item   (s1_in),
    .rd_data   (ram_rd_data),
    .wr        (ram_wr),
    .s1_ready  (s1_ready),
    .s2_ready  (s2_ready),
    .mag_valid (mag_valid),
    .mag_item  (mag_item)
  );

  lef_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .mag_valid (mag_valid),
    .mag_item  (mag_item),
    .gain      (edge_gain_r),
    .s2_ready  (s2_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  `LEF_ASSERT_NEXT(a_frame_start_col, in_fire && in_data.frame_start, col_count_r == lef_pkg::COL_W'(1), "frame start column")
  `LEF_ASSERT_NEXT(a_row_holds_in_line, in_fire && !in_data.frame_start && (col_inc < w_eff), row_count_r == $past(row_count_r), "row moved mid-line")

endmodule
